FILE: sv/fcb_pkg.sv
package fcb_pkg;

  // Command codes carried in req_type.
  localparam logic [2:0] REQ_PIXEL       = 3'd0;
  localparam logic [2:0] REQ_VLINE       = 3'd1;
  localparam logic [2:0] REQ_HLINE       = 3'd2;
  localparam logic [2:0] REQ_FILL        = 3'd3;
  localparam logic [2:0] REQ_BITMAP      = 3'd4;
  localparam logic [2:0] REQ_BITMAP_SWAP = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 2'd2;

  // Largest span that a descriptor can carry.
  localparam logic [11:0] SPAN_MAX = 12'd4095;

  // Configuration registers as seen by the pipeline stages.
  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [31:0] frame_base;
  } fcb_cfg_t;

  // One drawing command.
  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] size_w;
    logic signed [15:0] size_h;
    logic [15:0]        fill_color;
    logic [31:0]        src_base;
  } fcb_in_t;

  // One copy descriptor.
  typedef struct packed {
    logic        visible;
    logic [31:0] dest_start;
    logic [11:0] span_w;
    logic [11:0] span_h;
    logic [31:0] src_start;
    logic [15:0] src_skip;
    logic        swap_bytes;
    logic        pair_copy;
    logic [15:0] out_color;
  } fcb_out_t;

  // First stage: edge sums and range compares.
  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [15:0]        color;
    logic [31:0]        src_base;
    // Line: start, length and end along the line after turning it around.
    logic signed [17:0] la;
    logic signed [17:0] ll;
    logic signed [17:0] le;
    logic               lok;
    logic               lhit;
    // Bitmap: early reject and right or bottom overhang.
    logic               bok;
    logic               exh;
    logic               eyh;
    logic signed [17:0] wr;
    logic signed [17:0] hr;
    logic signed [17:0] skr;
  } fcb_s1_t;

  // Second stage: clipped geometry and multiplier operands.
  typedef struct packed {
    logic               visible;
    logic               bmp;
    logic               swap_bytes;
    logic               pair_copy;
    logic signed [15:0] col;
    logic signed [15:0] row;
    logic [11:0]        span_w;
    logic [11:0]        span_h;
    logic [15:0]        src_skip;
    logic [15:0]        color;
    logic [31:0]        src_base;
    logic signed [15:0] mul_y;
    logic signed [15:0] mul_w;
    logic signed [15:0] src_dx;
  } fcb_s2_t;

  // Third stage: row offsets from the multipliers.
  typedef struct packed {
    logic               visible;
    logic               bmp;
    logic               swap_bytes;
    logic               pair_copy;
    logic signed [15:0] col;
    logic [11:0]        span_w;
    logic [11:0]        span_h;
    logic [15:0]        src_skip;
    logic [15:0]        color;
    logic [31:0]        src_base;
    logic signed [15:0] src_dx;
    logic signed [28:0] prod_d;
    logic signed [31:0] prod_s;
  } fcb_s3_t;

endpackage

FILE: sv/framebuffer_clip_blit_descriptor.sv
// Turns one drawing command (pixel, vertical or horizontal line, filled
// rectangle, native or byte-swapped bitmap) into one copy descriptor with
// the clipped span, framebuffer and source start addresses, row skip and
// copy flags. The block is a four-stage pipeline: line and edge sums, clip
// selection, the two row-offset multipliers, and the final 32-bit address
// adders. It takes one command word every cycle unless a backed-up
// pipeline stalls it, and registers each word in every stage; a stall on the
// descriptor side only holds up stages that are occupied, so empty stages
// keep filling. Configuration registers take effect for commands accepted
// after the write and should be written only while the pipeline is empty.
module framebuffer_clip_blit_descriptor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  fcb_pkg::fcb_in_t                    cmd,
  output logic                                desc_valid,
  input  logic                                desc_stall,
  output fcb_pkg::fcb_out_t                   desc,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fcb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data
);
  import fcb_pkg::*;

  fcb_cfg_t cfg;
  fcb_s1_t  s1;
  fcb_s2_t  s2;
  fcb_s3_t  s3;
  logic     s1_valid, s2_valid, s3_valid;
  logic     en1, en2, en3, en4;

  // Configuration registers are always ready to take a word.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 12'd480;
      cfg.screen_height <= 12'd480;
      cfg.frame_base    <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[11:0];
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[11:0];
        CFG_FRAME_BASE:    cfg.frame_base    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves.
  assign en4       = !desc_valid || !desc_stall;
  assign en3       = !s3_valid || en4;
  assign en2       = !s2_valid || en3;
  assign en1       = !s1_valid || en2;
  assign cmd_stall = !en1;

  fcb_pre u_pre (
    .clk      (clk),
    .rst      (rst),
    .en       (en1),
    .in_valid (cmd_valid),
    .cmd      (cmd),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  fcb_clip u_clip (
    .clk      (clk),
    .rst      (rst),
    .en       (en2),
    .s1_valid (s1_valid),
    .s1       (s1),
    .cfg      (cfg),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  fcb_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .en       (en3),
    .s2_valid (s2_valid),
    .s2       (s2),
    .cfg      (cfg),
    .s3_valid (s3_valid),
    .s3       (s3)
  );

  fcb_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .en        (en4),
    .s3_valid  (s3_valid),
    .s3        (s3),
    .cfg       (cfg),
    .out_valid (desc_valid),
    .desc      (desc)
  );

endmodule

FILE: sv/fcb_pre.sv
module fcb_pre (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  fcb_pkg::fcb_in_t cmd,
  input  fcb_pkg::fcb_cfg_t cfg,
  output logic             s1_valid,
  output fcb_pkg::fcb_s1_t s1
);
  import fcb_pkg::*;

  logic signed [17:0] x18, y18, w18, h18, sw18, sh18;
  logic signed [17:0] p18, len18, c18, lima, limc;
  logic signed [17:0] ex, ey;
  logic               neg, hline;
  fcb_s1_t            s1_next;

  // Sign-extend the command and the screen size to a common width.
  assign x18  = 18'(cmd.pos_x);
  assign y18  = 18'(cmd.pos_y);
  assign w18  = 18'(cmd.size_w);
  assign h18  = 18'(cmd.size_h);
  assign sw18 = $signed({6'd0, cfg.screen_width});
  assign sh18 = $signed({6'd0, cfg.screen_height});

  // A horizontal line runs along x; every other line runs along y.
  assign hline = (cmd.req_type == REQ_HLINE);
  assign p18   = hline ? x18 : y18;
  assign len18 = hline ? w18 : h18;
  assign c18   = hline ? y18 : x18;
  assign lima  = hline ? sw18 : sh18;
  assign limc  = hline ? sh18 : sw18;
  assign neg   = len18[17];

  assign ex = x18 + w18 - 18'sd1;
  assign ey = y18 + h18 - 18'sd1;

  always_comb begin
    s1_next          = '0;
    s1_next.req_type = cmd.req_type;
    s1_next.x        = cmd.pos_x;
    s1_next.y        = cmd.pos_y;
    s1_next.w        = cmd.size_w;
    s1_next.h        = cmd.size_h;
    s1_next.color    = cmd.fill_color;
    s1_next.src_base = cmd.src_base;

    // Line: turn a negative length around so that it runs forward.
    s1_next.la   = neg ? (p18 + len18 + 18'sd1) : p18;
    s1_next.ll   = neg ? -len18 : len18;
    s1_next.le   = neg ? p18 : (p18 + len18 - 18'sd1);
    s1_next.lok  = !c18[17] && (c18 < limc) && (len18 != 18'sd0) &&
                   (s1_next.la < lima) && !s1_next.le[17];
    s1_next.lhit = (s1_next.le >= lima);

    // Bitmap: reject when wholly off screen, note overhangs.
    s1_next.bok = !(ex[17] || ey[17] || (x18 >= sw18) || (y18 >= sh18));
    s1_next.exh = (ex >= sw18);
    s1_next.eyh = (ey >= sh18);
    s1_next.wr  = sw18 - x18;
    s1_next.hr  = sh18 - y18;
    s1_next.skr = x18 + w18 - sw18;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

endmodule

FILE: sv/fcb_clip.sv
module fcb_clip (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              s1_valid,
  input  fcb_pkg::fcb_s1_t  s1,
  input  fcb_pkg::fcb_cfg_t cfg,
  output logic              s2_valid,
  output fcb_pkg::fcb_s2_t  s2
);
  import fcb_pkg::*;

  logic signed [17:0] sw18, sh18, lim, a0, l1;
  logic signed [17:0] x18, y18, w18, h18;
  logic signed [17:0] bx0, by0, w1, h1, sk;
  logic               bvis;
  fcb_s2_t            s2_next;

  // Clamp a positive span to what a descriptor can carry.
  function automatic logic [11:0] sat_span(input logic signed [17:0] v);
    if (v > 18'sd4095) begin
      return SPAN_MAX;
    end
    return v[11:0];
  endfunction

  assign sw18 = $signed({6'd0, cfg.screen_width});
  assign sh18 = $signed({6'd0, cfg.screen_height});
  assign x18  = 18'(s1.x);
  assign y18  = 18'(s1.y);
  assign w18  = 18'(s1.w);
  assign h18  = 18'(s1.h);

  // Line: clamp the start to the screen edge and trim the far end.
  assign lim = (s1.req_type == REQ_HLINE) ? sw18 : sh18;
  assign a0  = s1.la[17] ? 18'sd0 : s1.la;
  assign l1  = s1.lhit ? (lim - a0) : (s1.la[17] ? (s1.le + 18'sd1) : s1.ll);

  // Bitmap: trim the far overhang, then the near one.
  assign bx0  = x18[17] ? x18 : 18'sd0;
  assign by0  = y18[17] ? y18 : 18'sd0;
  assign h1   = (s1.eyh ? s1.hr : h18) + by0;
  assign w1   = (s1.exh ? s1.wr : w18) + bx0;
  assign sk   = (s1.exh ? s1.skr : 18'sd0) - bx0;
  assign bvis = s1.bok && !w1[17] && (w1 != 18'sd0) && !h1[17] && (h1 != 18'sd0);

  always_comb begin
    s2_next          = '0;
    s2_next.color    = s1.color;
    s2_next.src_base = s1.src_base;
    s2_next.mul_w    = s1.w;
    unique case (s1.req_type)
      REQ_PIXEL: begin
        s2_next.visible = 1'b1;
        s2_next.col     = s1.x;
        s2_next.row     = s1.y;
        s2_next.span_w  = 12'd1;
        s2_next.span_h  = 12'd1;
      end
      REQ_VLINE: begin
        s2_next.visible = s1.lok;
        s2_next.col     = s1.x;
        s2_next.row     = a0[15:0];
        s2_next.span_w  = s1.lok ? 12'd1 : 12'd0;
        s2_next.span_h  = s1.lok ? sat_span(l1) : 12'd0;
      end
      REQ_HLINE: begin
        s2_next.visible = s1.lok;
        s2_next.col     = a0[15:0];
        s2_next.row     = s1.y;
        s2_next.span_w  = s1.lok ? sat_span(l1) : 12'd0;
        s2_next.span_h  = s1.lok ? 12'd1 : 12'd0;
      end
      REQ_FILL: begin
        s2_next.visible = (s1.w > 16'sd0) && (s1.h > 16'sd0);
        s2_next.col     = s1.x;
        s2_next.row     = s1.y;
        s2_next.span_w  = s2_next.visible ? sat_span(w18) : 12'd0;
        s2_next.span_h  = s2_next.visible ? sat_span(h18) : 12'd0;
      end
      REQ_BITMAP, REQ_BITMAP_SWAP: begin
        s2_next.visible    = bvis;
        s2_next.bmp        = 1'b1;
        s2_next.col        = x18[17] ? 16'sd0 : s1.x;
        s2_next.row        = y18[17] ? 16'sd0 : s1.y;
        s2_next.span_w     = bvis ? sat_span(w1) : 12'd0;
        s2_next.span_h     = bvis ? sat_span(h1) : 12'd0;
        s2_next.src_skip   = bvis ? sk[15:0] : 16'd0;
        s2_next.swap_bytes = bvis && (s1.req_type == REQ_BITMAP_SWAP);
        s2_next.pair_copy  = bvis && (s1.req_type == REQ_BITMAP) &&
                             !cfg.screen_width[0] && !sk[0] && !w1[0];
        s2_next.mul_y      = by0[15:0];
        s2_next.src_dx     = bx0[15:0];
      end
      default: begin
        s2_next.visible = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
    end
  end

endmodule

FILE: sv/fcb_mul.sv
module fcb_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              s2_valid,
  input  fcb_pkg::fcb_s2_t  s2,
  input  fcb_pkg::fcb_cfg_t cfg,
  output logic              s3_valid,
  output fcb_pkg::fcb_s3_t  s3
);
  import fcb_pkg::*;

  logic signed [12:0] stride;
  fcb_s3_t            s3_next;

  assign stride = $signed({1'b0, cfg.screen_width});

  // Destination row offset and the source rows skipped above the screen.
  always_comb begin
    s3_next            = '0;
    s3_next.visible    = s2.visible;
    s3_next.bmp        = s2.bmp;
    s3_next.swap_bytes = s2.swap_bytes;
    s3_next.pair_copy  = s2.pair_copy;
    s3_next.col        = s2.col;
    s3_next.span_w     = s2.span_w;
    s3_next.span_h     = s2.span_h;
    s3_next.src_skip   = s2.src_skip;
    s3_next.color      = s2.color;
    s3_next.src_base   = s2.src_base;
    s3_next.src_dx     = s2.src_dx;
    s3_next.prod_d     = 29'(s2.row * stride);
    s3_next.prod_s     = 32'(s2.mul_y * s2.mul_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= s3_next;
    end
  end

endmodule

FILE: sv/fcb_sum.sv
module fcb_sum (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              s3_valid,
  input  fcb_pkg::fcb_s3_t  s3,
  input  fcb_pkg::fcb_cfg_t cfg,
  output logic              out_valid,
  output fcb_pkg::fcb_out_t desc
);
  import fcb_pkg::*;

  logic [31:0] dest_sum, src_sum;
  fcb_out_t    desc_next;

  // Final address sums; both wrap at 32 bits.
  assign dest_sum = cfg.frame_base + 32'(s3.prod_d) + 32'(s3.col);
  assign src_sum  = s3.src_base - s3.prod_s - 32'(s3.src_dx);

  always_comb begin
    desc_next            = '0;
    desc_next.visible    = s3.visible;
    desc_next.dest_start = s3.visible ? dest_sum : 32'd0;
    desc_next.span_w     = s3.span_w;
    desc_next.span_h     = s3.span_h;
    desc_next.src_start  = (s3.visible && s3.bmp) ? src_sum : 32'd0;
    desc_next.src_skip   = s3.src_skip;
    desc_next.swap_bytes = s3.swap_bytes;
    desc_next.pair_copy  = s3.pair_copy;
    desc_next.out_color  = s3.color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      desc <= desc_next;
    end
  end

endmodule

FILE: test/tb_framebuffer_clip_blit_descriptor.sv
`timescale 1ns / 1ps

import fcb_pkg::*;

// Keeps a copy of the screen registers, works out the descriptor of every
// accepted command, and checks each descriptor word against the oldest one.
class descriptor_checker;
  bit [11:0] scr_w;
  bit [11:0] scr_h;
  bit [31:0] fb_base;
  fcb_out_t  pending_descs[$];
  int        mismatches;
  int        descs_seen;
  int        visible_seen;
  int        per_type[8];

  function new();
    scr_w = 12'd480;
    scr_h = 12'd480;
    fb_base = 32'd0;
    mismatches = 0;
    descs_seen = 0;
    visible_seen = 0;
    foreach (per_type[i]) per_type[i] = 0;
  endfunction

  // Framebuffer address of a pixel; the sum wraps at 32 bits.
  function bit [31:0] frame_addr(longint col, longint row);
    longint off;
    off = row * longint'(scr_w) + col;
    return fb_base + off[31:0];
  endfunction

  function bit [11:0] clamp_span(longint v);
    return (v > longint'(SPAN_MAX)) ? SPAN_MAX : v[11:0];
  endfunction

  // Clip one command against the screen and build its descriptor.
  function fcb_out_t clip_command(fcb_in_t c);
    longint   x, y, w, h, maxx, maxy, y2, x2, orig_w, skip, s;
    fcb_out_t r;
    r = '0;
    r.out_color = c.fill_color;
    x = $signed(c.pos_x);
    y = $signed(c.pos_y);
    w = $signed(c.size_w);
    h = $signed(c.size_h);
    maxx = longint'(scr_w) - 1;
    maxy = longint'(scr_h) - 1;
    case (c.req_type)
      REQ_PIXEL: begin
        r.visible = 1'b1;
        r.dest_start = frame_addr(x, y);
        r.span_w = 12'd1;
        r.span_h = 12'd1;
      end
      REQ_VLINE: begin
        if (x >= 0 && x <= maxx && h != 0) begin
          // A line drawn upward is turned around to start at its top.
          if (h < 0) begin
            y += h + 1;
            h = -h;
          end
          if (y <= maxy) begin
            y2 = y + h - 1;
            if (y2 >= 0) begin
              if (y < 0) begin
                y = 0;
                h = y2 + 1;
              end
              if (y2 > maxy) h = maxy - y + 1;
              r.visible = 1'b1;
              r.dest_start = frame_addr(x, y);
              r.span_w = 12'd1;
              r.span_h = clamp_span(h);
            end
          end
        end
      end
      REQ_HLINE: begin
        if (y >= 0 && y <= maxy && w != 0) begin
          if (w < 0) begin
            x += w + 1;
            w = -w;
          end
          if (x <= maxx) begin
            x2 = x + w - 1;
            if (x2 >= 0) begin
              if (x < 0) begin
                x = 0;
                w = x2 + 1;
              end
              if (x2 > maxx) w = maxx - x + 1;
              r.visible = 1'b1;
              r.dest_start = frame_addr(x, y);
              r.span_w = clamp_span(w);
              r.span_h = 12'd1;
            end
          end
        end
      end
      REQ_FILL: begin
        if (w > 0 && h > 0) begin
          r.visible = 1'b1;
          r.dest_start = frame_addr(x, y);
          r.span_w = clamp_span(w);
          r.span_h = clamp_span(h);
        end
      end
      REQ_BITMAP, REQ_BITMAP_SWAP: begin
        if (!(x + w - 1 < 0 || y + h - 1 < 0 || x > maxx || y > maxy)) begin
          orig_w = w;
          skip = 0;
          s = longint'(c.src_base);
          // Trim bottom and top, then right and left; the source pointer
          // moves past the rows and columns that fall off the screen.
          if (y + h - 1 > maxy) h -= (y + h - 1) - maxy;
          if (y < 0) begin
            s -= y * orig_w;
            h += y;
            y = 0;
          end
          if (x + w - 1 > maxx) begin
            skip = (x + w - 1) - maxx;
            w -= skip;
          end
          if (x < 0) begin
            s -= x;
            skip -= x;
            w += x;
            x = 0;
          end
          if (w > 0 && h > 0) begin
            r.visible = 1'b1;
            r.dest_start = frame_addr(x, y);
            r.span_w = clamp_span(w);
            r.span_h = clamp_span(h);
            r.src_start = s[31:0];
            r.src_skip = skip[15:0];
            r.swap_bytes = (c.req_type == REQ_BITMAP_SWAP);
            r.pair_copy = (c.req_type == REQ_BITMAP) && !scr_w[0] && !skip[0] && !w[0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function void note_command(fcb_in_t c);
    per_type[c.req_type]++;
    pending_descs.push_back(clip_command(c));
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at descriptor %0d: %s", descs_seen, msg);
    mismatches++;
  endtask

  task check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  task check_descriptor(fcb_out_t d);
    fcb_out_t e;
    descs_seen++;
    if (pending_descs.size() == 0) begin
      report_mismatch($sformatf("word %h with no command waiting", d));
      return;
    end
    e = pending_descs.pop_front();
    if (e.visible) visible_seen++;
    check_field("visible", d.visible, e.visible);
    check_field("dest_start", d.dest_start, e.dest_start);
    check_field("span_w", d.span_w, e.span_w);
    check_field("span_h", d.span_h, e.span_h);
    check_field("src_start", d.src_start, e.src_start);
    check_field("src_skip", d.src_skip, e.src_skip);
    check_field("swap_bytes", d.swap_bytes, e.swap_bytes);
    check_field("pair_copy", d.pair_copy, e.pair_copy);
    check_field("out_color", d.out_color, e.out_color);
  endtask
endclass

module tb_framebuffer_clip_blit_descriptor;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD = 200;

  logic                 clk;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_stall;
  fcb_in_t              cmd;
  logic                 desc_valid;
  logic                 desc_stall;
  fcb_out_t             desc;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  descriptor_checker sb;
  bit                no_idle;
  bit                long_hold;
  int                idle_cycles;
  int                settings_used;

  framebuffer_clip_blit_descriptor dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc       (desc),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every descriptor word taken from the block is checked.
  always @(posedge clk) begin
    if (!rst && desc_valid && !desc_stall) sb.check_descriptor(desc);
  end

  // Give up when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (desc_valid && !desc_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Descriptor side: stall a random number of cycles before each word, or
  // once for a long stretch so that the pipeline backs up.
  initial begin
    int n;
    forever begin
      if (long_hold) begin
        n = LONG_HOLD;
        long_hold = 1'b0;
      end else if (no_idle) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 10);
      end
      repeat (n) begin
        @(negedge clk);
        desc_stall <= 1'b1;
      end
      @(negedge clk);
      desc_stall <= 1'b0;
      do @(posedge clk); while (desc_valid !== 1'b1);
    end
  end

  // Offer one command word after a random gap and hold it until taken.
  task automatic send_command(fcb_in_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    sb.note_command(c);
  endtask

  task automatic drain_commands();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (sb.pending_descs.size() != 0) @(posedge clk);
  endtask

  // Write all three screen registers back to back; the block is empty here.
  task automatic program_screen(logic [11:0] w, logic [11:0] h, logic [31:0] base);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [31:0]          val[3];
    idx = '{CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT, CFG_FRAME_BASE};
    val = '{32'(w), 32'(h), base};
    repeat (6) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_SCREEN_WIDTH:  sb.scr_w = val[i][11:0];
        CFG_SCREEN_HEIGHT: sb.scr_h = val[i][11:0];
        CFG_FRAME_BASE:    sb.fb_base = val[i];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic fcb_in_t shape(logic [2:0] t, int x, int y, int w, int h);
    fcb_in_t c;
    c.req_type = t;
    c.pos_x = 16'(x);
    c.pos_y = 16'(y);
    c.size_w = 16'(w);
    c.size_h = 16'(h);
    c.fill_color = 16'($urandom);
    c.src_base = $urandom;
    return c;
  endfunction

  // Positions cluster around the visible area, with corners and wild values.
  function automatic logic [15:0] pick_pos(int extent);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 16'($urandom);
    if (r < 22) begin
      case ($urandom_range(0, 3))
        0: return 16'(-1);
        1: return 16'(0);
        2: return 16'(extent - 1);
        default: return 16'(extent);
      endcase
    end
    return 16'(int'($urandom_range(0, extent + 96)) - 48);
  endfunction

  // Sizes are mostly short, some span the screen, a few are anything.
  function automatic logic [15:0] pick_size(int extent);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 16'($urandom);
    if (r < 30) return 16'(int'($urandom_range(0, 2 * extent + 2)) - extent - 1);
    return 16'(int'($urandom_range(0, 48)) - 8);
  endfunction

  function automatic fcb_in_t random_command();
    fcb_in_t c;
    c.req_type = ($urandom_range(0, 99) < 4) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
    c.pos_x = pick_pos(int'(sb.scr_w));
    c.pos_y = pick_pos(int'(sb.scr_h));
    c.size_w = pick_size(int'(sb.scr_w));
    c.size_h = pick_size(int'(sb.scr_h));
    c.fill_color = 16'($urandom);
    c.src_base = $urandom;
    return c;
  endfunction

  // Hand-picked commands for the 480 x 480 screen left by reset.
  task automatic send_directed();
    fcb_in_t c;
    send_command(shape(REQ_PIXEL, 0, 0, 1, 1));
    send_command(shape(REQ_PIXEL, -32768, 32767, 0, 0));
    send_command(shape(REQ_PIXEL, 32767, -32768, -1, -1));
    send_command(shape(REQ_VLINE, 10, 100, 0, -50));
    send_command(shape(REQ_VLINE, 10, 100, 5, 0));
    send_command(shape(REQ_VLINE, 5, -10, 0, 30));
    send_command(shape(REQ_VLINE, 5, 470, 0, 32767));
    send_command(shape(REQ_VLINE, 480, 0, 0, 10));
    send_command(shape(REQ_HLINE, 100, 10, -200, 0));
    send_command(shape(REQ_HLINE, -100, 5, 1000, 7));
    send_command(shape(REQ_HLINE, 32767, 0, -32768, 0));
    send_command(shape(REQ_HLINE, 0, 479, 0, 0));
    send_command(shape(REQ_FILL, 0, 0, 32767, 32767));
    send_command(shape(REQ_FILL, 20, 20, 0, 5));
    send_command(shape(REQ_FILL, 20, 20, 5, -32768));
    send_command(shape(REQ_BITMAP, 10, 10, 8, 4));
    send_command(shape(REQ_BITMAP_SWAP, 10, 10, 8, 4));
    send_command(shape(REQ_BITMAP, -3, -2, 10, 10));
    send_command(shape(REQ_BITMAP, 475, 478, 10, 10));
    send_command(shape(REQ_BITMAP, -20000, -20000, 32767, 32767));
    send_command(shape(REQ_BITMAP, -32768, -32768, 32767, 32767));
    send_command(shape(REQ_BITMAP_SWAP, 5, 5, 0, 10));
    send_command(shape(REQ_BITMAP, 5, 5, -4, 10));
    send_command(shape(3'd6, 1, 1, 1, 1));
    c = shape(3'd7, -1, -1, -1, -1);
    c.fill_color = 16'hFFFF;
    c.src_base = 32'hFFFF_FFFF;
    send_command(c);
  endtask

  task automatic send_random(int count, bit pause_midway, bit back_up);
    if (back_up) begin
      long_hold = 1'b1;
      no_idle = 1'b1;
    end
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0 && !(back_up && i == 0)) no_idle = ($urandom_range(0, 3) == 0);
      if (pause_midway && i == count / 2) drain_commands();
      send_command(random_command());
    end
    drain_commands();
  endtask

  initial begin
    sb = new();
    no_idle = 1'b0;
    long_hold = 1'b0;
    idle_cycles = 0;
    settings_used = 1;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    desc_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SCREEN_WIDTH;
    cfg_data = 32'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset screen first, then a run of settings between the extremes.
    send_directed();
    send_random(110, 1'b0, 1'b0);
    program_screen(12'd1, 12'd1, 32'hFFFF_FFFF);
    send_random(100, 1'b0, 1'b0);
    program_screen(12'd4095, 12'd4095, $urandom);
    send_random(120, 1'b1, 1'b0);
    program_screen(12'd640, 12'd480, $urandom);
    send_random(130, 1'b0, 1'b1);
    program_screen(12'd479, 12'd271, $urandom);
    send_random(130, 1'b0, 1'b0);
    // A zero-sized screen clips every line and bitmap away.
    program_screen(12'd0, 12'd0, $urandom);
    send_random(40, 1'b0, 1'b0);
    program_screen(12'd2, 12'd4095, $urandom);
    send_random(80, 1'b0, 1'b0);
    program_screen(12'd4095, 12'd1, 32'h8000_0000);
    send_random(90, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    $display("Covered %0d commands under %0d screen settings: %0d drawn, %0d clipped away.",
             sb.descs_seen, settings_used, sb.visible_seen, sb.descs_seen - sb.visible_seen);
    $display("Per type: pixel %0d, vline %0d, hline %0d, fill %0d, bitmap %0d, swapped %0d, other %0d.",
             sb.per_type[REQ_PIXEL], sb.per_type[REQ_VLINE], sb.per_type[REQ_HLINE],
             sb.per_type[REQ_FILL], sb.per_type[REQ_BITMAP], sb.per_type[REQ_BITMAP_SWAP],
             sb.per_type[6] + sb.per_type[7]);
    if (sb.mismatches == 0 && sb.pending_descs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
